/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/fpfe_pkg.sv */
// Package for the float pixel format encoder: pixel type codes and widths.
// No dependencies.
package fpfe_pkg;
  localparam int unsigned InW = 32;
  localparam int unsigned OutW = 64;
  localparam int unsigned CntW = 4;
  localparam int unsigned TypeW = 3;

  typedef enum logic [TypeW-1:0] {
    PT_U8 = 3'd0,
    PT_U16 = 3'd1,
    PT_U32 = 3'd2,
    PT_F32A = 3'd3,
    PT_HALF = 3'd4,
    PT_F32PAD = 3'd5,
    PT_HALFPAD = 3'd6,
    PT_F32B = 3'd7
  } pixel_type_e;

  localparam logic [TypeW-1:0] PixelTypeReset = PT_U8;
endpackage

/* rtl/core/float_pixel_format_encoder_top.sv */
// Top level of the float pixel format encoder.
// Depends on fpfe_pkg.
//
// Converts one float32 pixel per cycle, when the output does not stall, into
// u8/u16/u32 (clamped, rounded half away from zero), half float (truncated) or
// float32, big-endian and right-aligned in out_data_o with byte_count_o valid
// bytes. An item is registered at the input, converted by one level of
// combinational logic (a 24-bit barrel shift with rounding add sets the path)
// and registered at the output. pixel_type is written through its own channel;
// the user must do so only while the block is idle, as the block does not enforce it.
module float_pixel_format_encoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fpfe_pkg::TypeW-1:0]  cfg_pixel_type_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fpfe_pkg::InW-1:0]    pixel_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fpfe_pkg::OutW-1:0]   out_data_o,
  output logic [fpfe_pkg::CntW-1:0]   byte_count_o
);
  import fpfe_pkg::*;

  logic [TypeW-1:0] type_q;
  logic             s1_valid_q;
  logic [InW-1:0]   s1_bits_q;
  logic             out_valid_q;
  logic [OutW-1:0]  data_q, data_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             adv_out, adv_s1;

  assign cfg_ready_o = 1'b1;
  assign adv_out = !out_valid_q || out_ready_i;
  assign adv_s1 = !s1_valid_q || adv_out;
  assign in_ready_o = adv_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= PixelTypeReset;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) type_q <= cfg_pixel_type_i;
      if (adv_s1) s1_valid_q <= in_valid_i;
      if (adv_out) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && in_valid_i) s1_bits_q <= pixel_bits_i;
    if (adv_out && s1_valid_q) begin
      data_q <= data_d;
      cnt_q <= cnt_d;
    end
  end

  // Field decode
  logic [7:0]  exp_w;
  logic [22:0] man_w;
  logic        sgn_w, is_nan, is_inf;
  assign sgn_w = s1_bits_q[31];
  assign exp_w = s1_bits_q[30:23];
  assign man_w = s1_bits_q[22:0];
  assign is_nan = (exp_w == 8'hFF) && (man_w != '0);
  assign is_inf = (exp_w == 8'hFF) && (man_w == '0);

  // Integer magnitude: rounded value for exponents 126..158 (below 2^32)
  logic [32:0] uval;
  logic [4:0]  rsh;
  logic [55:0] wide;
  always_comb begin
    uval = '0;
    rsh = '0;
    wide = '0;
    if (exp_w >= 8'd150) begin
      wide = {32'd0, 1'b1, man_w} << (exp_w - 8'd150);
      uval = wide[32:0];
    end else begin
      rsh = 5'(8'd150 - exp_w);
      wide = {32'd0, 1'b1, man_w} + (56'd1 << (rsh - 5'd1));
      uval = 33'(wide >> rsh);
    end
  end

  logic uzero, umax_big;
  assign uzero = sgn_w || (exp_w < 8'd126);
  assign umax_big = is_inf || (exp_w >= 8'd159);

  logic [7:0]  u8v;
  logic [15:0] u16v;
  logic [31:0] u32v;
  always_comb begin
    if (is_nan) begin
      u8v = '0; u16v = '1; u32v = '1;
    end else if (uzero) begin
      u8v = '0; u16v = '0; u32v = '0;
    end else if (umax_big) begin
      u8v = '1; u16v = '1; u32v = '1;
    end else begin
      u8v = (uval > 33'd255) ? 8'hFF : uval[7:0];
      u16v = (uval > 33'd65535) ? 16'hFFFF : uval[15:0];
      u32v = (uval[32]) ? 32'hFFFF_FFFF : uval[31:0];
    end
  end

  // Half conversion; biased half exponent = exp - 112
  logic [15:0] half;
  logic [23:0] dsh;
  always_comb begin
    dsh = {1'b1, man_w} >> (8'd126 - exp_w);
    if (exp_w == 8'hFF) begin
      half = (man_w != '0) ? 16'h7FFF : {sgn_w, 15'h7C00};
    end else if (exp_w <= 8'd112) begin
      if (exp_w < 8'd102) half = {sgn_w, 15'd0};
      else half = {sgn_w, 5'd0, dsh[9:0]};
    end else if (exp_w >= 8'd143) begin
      half = {sgn_w, 15'h7C00};
    end else begin
      half = {sgn_w, 5'(exp_w - 8'd112), man_w[22:13]};
    end
  end

  always_comb begin
    case (pixel_type_e'(type_q))
      PT_U8: begin data_d = {56'd0, u8v}; cnt_d = 4'd1; end
      PT_U16: begin data_d = {48'd0, u16v}; cnt_d = 4'd2; end
      PT_U32: begin data_d = {32'd0, u32v}; cnt_d = 4'd4; end
      PT_HALF: begin data_d = {48'd0, half}; cnt_d = 4'd2; end
      PT_F32PAD: begin data_d = {s1_bits_q, 32'd0}; cnt_d = 4'd8; end
      PT_HALFPAD: begin data_d = {32'd0, half, 16'd0}; cnt_d = 4'd4; end
      default: begin data_d = {32'd0, s1_bits_q}; cnt_d = 4'd4; end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = data_q;
  assign byte_count_o = cnt_q;
endmodule

/* rtl/core/fpfe_checker.sv */
// Port-level checker for the float pixel format encoder, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module fpfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] out_data_o,
  input logic [3:0]  byte_count_o
);
  `ASSERT_IMPL(a_cnt_legal, clk_i, rst_ni, out_valid_o,
    byte_count_o == 4'd1 || byte_count_o == 4'd2 || byte_count_o == 4'd4 || byte_count_o == 4'd8)
  `ASSERT_IMPL(a_one_byte_clean, clk_i, rst_ni, out_valid_o && byte_count_o == 4'd1,
    out_data_o[63:8] == '0)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))
  `ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o)
endmodule

bind float_pixel_format_encoder_top fpfe_checker u_fpfe_checker (.*);

/* tb/sv/tb.sv */
// Testbench for float_pixel_format_encoder_top: drives float32 pixels under
// every pixel type and checks each encoded result against a local predictor.
// Depends on fpfe_pkg and the encoder top level.
module tb;
  import fpfe_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [TypeW-1:0]   cfg_pixel_type_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [InW-1:0]     pixel_bits_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [OutW-1:0]    out_data_o;
  logic [CntW-1:0]    byte_count_o;

  typedef struct packed {
    logic [OutW-1:0] data;
    logic [CntW-1:0] count;
  } encoded_t;

  encoded_t    pending_q[$];
  pixel_type_e cur_type;
  int          err_cnt;
  int          hold_cycles;
  bit          rand_stall;

  float_pixel_format_encoder_top DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Clamp and round half away from zero on raw float32 bits.
  function automatic logic [63:0] sat_uint(logic [31:0] b, logic [63:0] maxv, bit nan_max);
    logic [7:0]  e;
    logic [22:0] m;
    logic [63:0] mant;
    logic [63:0] v;
    int          s;
    e = b[30:23];
    m = b[22:0];
    if (e == 8'hFF && m != 0) return nan_max ? maxv : 64'd0;
    if (b[31]) return 64'd0;
    if (e == 8'hFF) return maxv;
    if (e < 126) return 64'd0;
    if (e >= 159) return maxv;
    mant = {40'd0, 1'b1, m};
    if (e >= 150) v = mant << (e - 150);
    else begin
      s = 150 - e;
      v = (mant + (64'd1 << (s - 1))) >> s;
    end
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic logic [15:0] trunc_half(logic [31:0] b);
    logic [15:0] sgn;
    int          he;
    sgn = {b[31], 15'd0};
    if (b[30:23] == 8'hFF) return (b[22:0] != 0) ? 16'h7FFF : (sgn | 16'h7C00);
    he = int'(b[30:23]) - 112;
    if (he <= 0) begin
      if (he < -10) return sgn;
      return sgn | 16'(({1'b1, b[22:0]}) >> (14 - he));
    end
    if (he >= 31) return sgn | 16'h7C00;
    return sgn | {1'b0, 5'(he), b[22:13]};
  endfunction

  function automatic encoded_t encode_pixel(pixel_type_e t, logic [31:0] b);
    encoded_t r;
    case (t)
      PT_U8:      r = '{sat_uint(b, 64'd255, 1'b0), 4'd1};
      PT_U16:     r = '{sat_uint(b, 64'd65535, 1'b1), 4'd2};
      PT_U32:     r = '{sat_uint(b, 64'hFFFF_FFFF, 1'b1), 4'd4};
      PT_HALF:    r = '{{48'd0, trunc_half(b)}, 4'd2};
      PT_F32PAD:  r = '{{b, 32'd0}, 4'd8};
      PT_HALFPAD: r = '{{32'd0, trunc_half(b), 16'd0}, 4'd4};
      default:    r = '{{32'd0, b}, 4'd4};
    endcase
    return r;
  endfunction

  task automatic wait_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Valid stays up after an accept when the next item follows without a gap.
  task automatic send_pixel(logic [31:0] b, bit gaps);
    if (gaps) wait_gap();
    in_valid_i   <= 1'b1;
    pixel_bits_i <= b;
    pending_q.push_back(encode_pixel(cur_type, b));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_type(pixel_type_e t);
    drain();
    cfg_valid_i      <= 1'b1;
    cfg_pixel_type_i <= t;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_type = t;
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] b;
    b = $urandom();
    case ($urandom_range(0, 5))
      0: b[30:23] = 8'($urandom_range(100, 165));
      1: b[30:23] = 8'($urandom_range(100, 145));
      2: b[30:23] = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
      3: b = {1'b0, 8'($urandom_range(126, 134)), 23'($urandom) & 23'h7F0000};
      default: ;
    endcase
    return b;
  endfunction

  task automatic test_directed();
    logic [31:0] edges[] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                             32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                             32'h3F00_0000, 32'h3EFF_FFFF, 32'h3FC0_0000, 32'h437F_0000,
                             32'h437F_8000, 32'h477F_FF00, 32'h4F80_0000, 32'h4F7F_FFFF,
                             32'h7F7F_FFFF, 32'h4780_0000, 32'h3380_0000, 32'h3300_0000,
                             32'h387F_E000, 32'hC780_0000, 32'h4B00_0001, 32'h5F80_0000};
    for (int t = 0; t < 8; t++) begin
      set_type(pixel_type_e'(t));
      foreach (edges[i]) send_pixel(edges[i], 1'b0);
    end
  endtask

  task automatic test_random_types();
    pixel_type_e order[] = '{PT_U8, PT_F32B, PT_U32, PT_HALF, PT_U16, PT_HALFPAD,
                             PT_F32PAD, PT_F32A};
    foreach (order[k]) begin
      set_type(order[k]);
      repeat (70) send_pixel(rand_pixel(), 1'b1);
    end
  endtask

  // Receiver holds off while the sender keeps pushing items.
  task automatic test_backpressure();
    set_type(PT_HALF);
    hold_cycles = 60;
    repeat (40) send_pixel(rand_pixel(), 1'b0);
    drain();
    repeat (40) send_pixel(rand_pixel(), 1'b1);
  endtask

  task automatic test_back_to_back();
    set_type(PT_U16);
    rand_stall = 1'b0;
    repeat (60) send_pixel(rand_pixel(), 1'b0);
    rand_stall = 1'b1;
    set_type(PT_U8);
    repeat (60) send_pixel(rand_pixel(), 1'b1);
  endtask

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (!rand_stall) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    encoded_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item data=%h count=%0d", $time, out_data_o, byte_count_o);
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_data_o !== exp_r.data) begin
          $display("%0t: out_data expected %h actual %h", $time, exp_r.data, out_data_o);
          err_cnt++;
        end
        if (byte_count_o !== exp_r.count) begin
          $display("%0t: byte_count expected %0d actual %0d", $time, exp_r.count,
                   byte_count_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    err_cnt          = 0;
    hold_cycles      = 0;
    rand_stall       = 1'b1;
    cur_type         = PT_U8;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_pixel_type_i = PT_U8;
    in_valid_i       = 1'b0;
    pixel_bits_i     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset value of the type register
    repeat (8) send_pixel(rand_pixel(), 1'b1);
    test_directed();
    test_random_types();
    test_backpressure();
    test_back_to_back();
    drain();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/fpfe_pkg.sv
rtl/core/float_pixel_format_encoder_top.sv
rtl/core/fpfe_checker.sv
tb/sv/tb.sv
